// ===== rtl/core/setq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// setq_pkg
// Types and constants shared by the sorted expiry timer queue.
// ----------------------------------------------------------------------------
package setq_pkg;

   localparam int ID_W     = 16;
   localparam int TIME_W   = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;

   // most expired timers drained by one tick
   localparam int RESULT_LIMIT = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD    = 2'd0,
      ACT_ADJUST = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_TICK   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_NOTHING   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND,
      S_REMOVE,
      S_INSERT,
      S_TICK_COUNT,
      S_TICK_EMIT_RD,
      S_TICK_EMIT_WAIT,
      S_TICK_SHIFT,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   owner;
      logic [TIME_W-1:0] expiry;
   } entry_type;

endpackage : setq_pkg
`default_nettype wire

// ===== rtl/core/setq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// setq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module setq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : setq_ram
`default_nettype wire

// ===== rtl/core/sorted_expiry_timer_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_expiry_timer_queue
// Table of connection timers kept sorted by expiry time in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transaction: add, adjust, delete or tick.
//   rsp_* returns the results. Add, adjust and delete give one result with a
//   status. A tick gives one result per expired timer in expiry order, the
//   final one marked by rsp_tlast, or one nothing-expired result.
//   Commands are handled one at a time; req_tready is high only while the
//   sequencer is idle. The result register lets the next command in while
//   the final result of the previous one still waits.
//   Steps per command, with C live entries and one RAM read per cycle in a pass:
//     add/adjust/delete: an id search over up to C entries, then, where the
//     table changes, a shift pass over up to C entries (adjust does a
//     removal and an insertion), then the reply is placed.
//     tick draining N timers: a pass to count them, a RAM read per result,
//     then a shift of the remaining C-N entries to close the gap.
//   The single read port of the table RAM sets this pacing.
//   Reset empties the table at once; the RAM needs no clearing pass.
//   A stalled rsp_tready holds the current result and pauses the sequencer
//   at its next result.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_queue #(
   parameter int TABLE_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: conn_id[15:0], expire_time[47:16], now_time[79:48]
   // req_tuser: action[1:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   // rsp_tdata: owner_id[15:0]
   // rsp_tuser: expired[0], status[3:1]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic [3:0]       rsp_tuser,
   output logic             rsp_tlast
);

   import setq_pkg::*;

   localparam int IW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int BOUND = (TABLE_DEPTH < RESULT_LIMIT) ? TABLE_DEPTH : RESULT_LIMIT;
   localparam int EW    = $bits(entry_type);

   state_type         state_ff, state_in;
   action_type        action_ff, action_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     didx_ff, didx_in;
   logic              dv_ff, dv_in;
   logic [CW-1:0]     n_ff, n_in;
   status_type        status_ff, status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_exp_ff, rsp_exp_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   entry_type         wr_data;
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   entry_type         rd_data;

   logic              req_fire;
   logic              slot_free;
   logic              more;
   logic              tick_more;
   logic              find_hit;
   logic              pass_end;
   logic              ins_place;
   logic              ins_stop;
   logic              tick_stop;
   logic              emit_last;
   logic              table_full;

   setq_ram #(
      .WIDTH(EW),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign more       = (ptr_ff < count_ff);
   assign tick_more  = more && (ptr_ff < CW'(BOUND));
   assign find_hit   = dv_ff && (rd_data.owner == id_ff);
   assign pass_end   = !more && !dv_ff;
   assign ins_place  = dv_ff && (rd_data.expiry <= time_ff);
   assign ins_stop   = ins_place || (!dv_ff && (ptr_ff == '0));
   assign tick_stop  = (dv_ff && (rd_data.expiry > now_ff)) || (!dv_ff && !tick_more);
   assign emit_last  = ((ptr_ff + CW'(1)) == n_ff);
   assign table_full = (count_ff == CW'(TABLE_DEPTH));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (action_type'(req_tuser) == ACT_TICK) ? S_TICK_COUNT : S_FIND;
            end
         end
         S_FIND: begin
            if (find_hit) begin
               state_in = (action_ff == ACT_ADD) ? S_REPLY : S_REMOVE;
            end else if (pass_end) begin
               if (action_ff == ACT_ADD) begin
                  state_in = table_full ? S_REPLY : S_INSERT;
               end else begin
                  state_in = S_REPLY;
               end
            end
         end
         S_REMOVE: begin
            if (pass_end) begin
               state_in = (action_ff == ACT_ADJUST) ? S_INSERT : S_REPLY;
            end
         end
         S_INSERT: begin
            if (ins_stop) begin
               state_in = S_REPLY;
            end
         end
         S_TICK_COUNT: begin
            if (tick_stop) begin
               state_in = (n_ff == '0) ? S_REPLY : S_TICK_EMIT_RD;
            end
         end
         S_TICK_EMIT_RD: begin
            state_in = S_TICK_EMIT_WAIT;
         end
         S_TICK_EMIT_WAIT: begin
            if (slot_free) begin
               state_in = emit_last ? S_TICK_SHIFT : S_TICK_EMIT_RD;
            end
         end
         S_TICK_SHIFT: begin
            if (pass_end) begin
               state_in = S_IDLE;
            end
         end
         S_REPLY: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      action_in     = action_ff;
      id_in         = id_ff;
      time_in       = time_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      didx_in       = didx_ff;
      n_in          = n_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = IW'(ptr_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               action_in = action_type'(req_tuser);
               id_in     = req_tdata[15:0];
               time_in   = req_tdata[47:16];
               now_in    = req_tdata[79:48];
               ptr_in    = '0;
               n_in      = '0;
            end
         end
         S_FIND: begin
            if (more) begin
               rd_en   = 1'b1;
               didx_in = ptr_ff;
               ptr_in  = ptr_ff + CW'(1);
            end
            if (find_hit) begin
               if (action_ff == ACT_ADD) begin
                  status_in = ST_DUPLICATE;
               end else begin
                  ptr_in = didx_ff + CW'(1);
               end
            end else if (pass_end) begin
               if (action_ff == ACT_ADD) begin
                  status_in = table_full ? ST_FULL : ST_OK;
                  ptr_in    = count_ff;
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
         end
         S_REMOVE: begin
            // pull each later entry down by one
            if (more) begin
               rd_en   = 1'b1;
               didx_in = ptr_ff;
               ptr_in  = ptr_ff + CW'(1);
            end
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_addr = IW'(didx_ff - CW'(1));
            end
            if (pass_end) begin
               count_in  = count_ff - CW'(1);
               ptr_in    = count_ff - CW'(1);
               status_in = ST_OK;
            end
         end
         S_INSERT: begin
            // walk down from the back, pushing later entries up by one
            rd_addr = IW'(ptr_ff - CW'(1));
            if (ptr_ff != '0) begin
               rd_en   = 1'b1;
               didx_in = ptr_ff - CW'(1);
               ptr_in  = ptr_ff - CW'(1);
            end
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_addr = IW'(didx_ff + CW'(1));
            end
            if (ins_stop) begin
               wr_en          = 1'b1;
               wr_addr        = ins_place ? IW'(didx_ff + CW'(1)) : '0;
               wr_data.owner  = id_ff;
               wr_data.expiry = time_ff;
               count_in       = count_ff + CW'(1);
               status_in      = ST_OK;
            end
         end
         S_TICK_COUNT: begin
            if (tick_more) begin
               rd_en   = 1'b1;
               didx_in = ptr_ff;
               ptr_in  = ptr_ff + CW'(1);
            end
            if (dv_ff && (rd_data.expiry <= now_ff)) begin
               n_in = didx_ff + CW'(1);
            end
            if (tick_stop) begin
               ptr_in    = '0;
               status_in = ST_NOTHING;
            end
         end
         S_TICK_EMIT_RD: begin
            rd_en = 1'b1;
         end
         S_TICK_EMIT_WAIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = rd_data.owner;
               rsp_exp_in    = 1'b1;
               rsp_status_in = ST_OK;
               rsp_last_in   = emit_last;
               ptr_in        = emit_last ? n_ff : (ptr_ff + CW'(1));
            end
         end
         S_TICK_SHIFT: begin
            // close the gap left by the drained entries
            if (more) begin
               rd_en   = 1'b1;
               didx_in = ptr_ff;
               ptr_in  = ptr_ff + CW'(1);
            end
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_addr = IW'(didx_ff - n_ff);
            end
            if (pass_end) begin
               count_in = count_ff - n_ff;
            end
         end
         S_REPLY: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = '0;
               rsp_exp_in    = 1'b0;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // drop read data that belongs to a pass already left
   assign dv_in = rd_en && (state_in == state_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      id_ff         <= id_in;
      time_ff       <= time_in;
      now_ff        <= now_in;
      ptr_ff        <= ptr_in;
      didx_ff       <= didx_in;
      n_ff          <= n_in;
      status_ff     <= status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_exp_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !wr_en)
      else $error("table written while idle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("accepted command not started");

   a_expired_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_exp_ff |-> rsp_status_ff == ST_OK)
      else $error("expired result with error status");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) && !$past(reset) |->
         ($past(state_ff) == S_REMOVE || $past(state_ff) == S_INSERT ||
          $past(state_ff) == S_TICK_SHIFT))
      else $error("entry count changed outside an update pass");

endmodule : sorted_expiry_timer_queue
`default_nettype wire
